>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the audio sample FIFO.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, disabled while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication: cause at this edge, effect at the next.
`define ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

>>> rtl/core/pasf_pkg.sv
// Package for the prebuffered audio sample FIFO: payload structs, action and
// register codes, widths and reset values. No dependencies.
package pasf_pkg;

    // Widths fixed by the item and register formats
    localparam int LEVEL_W    = 12;
    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 32;
    localparam int SCALED_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Default ring depth
    localparam int DEF_RING_DEPTH = 2048;

    // Action codes
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_PULL  = 2'd1;
    localparam logic [1:0] ACT_FRAME = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME_FLOOR = 3'd4;

    // Register reset values
    localparam logic [2:0]         RST_VOLUME       = 3'd7;
    localparam logic               RST_SOUND_ENABLE = 1'b1;
    localparam logic [LEVEL_W-1:0] RST_START_LEVEL  = 12'd740;
    localparam logic [LEVEL_W-1:0] RST_FILL_LIMIT   = 12'd1480;
    localparam logic [LEVEL_W-1:0] RST_RESUME_FLOOR = 12'd370;

    // Full-gain volume code (no scaling, no shift)
    localparam logic [2:0] VOL_FULL = 3'd7;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] sample_byte;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]  stereo_word;
        logic               accepted;
        logic               underrun;
        logic               playing;
        logic [LEVEL_W-1:0] fill_level;
    } t_out_item;

endpackage

>>> rtl/core/pasf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pasf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/prebuffered_audio_sample_fifo.sv
// Top level of the prebuffered audio sample FIFO.
// Depends on pasf_pkg, pasf_ram and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes push, pull and
//   frame-check items. Output channel (o_out_valid / i_out_ready / o_out_item)
//   gives one result item per input item, in order. Configuration channel
//   (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) writes volume,
//   sound enable, start level, fill limit and resume floor; it is always ready
//   and should be used only while no item is in flight.
//   Each item is handled in an accept cycle and an execute state: the accept
//   cycle reads the sample ring at the read pointer and does the gain multiply;
//   the execute state multiplies by 127, writes the ring and updates pointers,
//   fill count and prebuffer flag. The registered read of the ring memory sets
//   this split. The result is registered and shows on o_out_valid in the cycle
//   after the commit. No new item is accepted until the execute state commits.
//   A result waits in the output register while the receiver stalls; one more
//   item may be accepted meanwhile and holds in the execute state until the
//   output register frees.
//   Reset clears pointers and fill count, sets prebuffering and loads the
//   register defaults. Ring contents are not cleared; no clearing pass runs.
`include "assert_macros.svh"

module prebuffered_audio_sample_fifo #(
    parameter int RING_DEPTH = pasf_pkg::DEF_RING_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pasf_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pasf_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pasf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pasf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int XW = (CW > pasf_pkg::LEVEL_W) ? CW : pasf_pkg::LEVEL_W;
    localparam int SW = pasf_pkg::SAMPLE_W;
    localparam int LW = pasf_pkg::LEVEL_W;
    localparam int SCALED_W = pasf_pkg::SCALED_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Configuration registers
    logic [2:0]    r_volume;
    logic          r_sound_enable;
    logic [LW-1:0] r_start_level;
    logic [LW-1:0] r_fill_limit;
    logic [LW-1:0] r_resume_floor;

    // Control state
    t_state        r_state, n_state;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_fill_count, n_fill_count;
    logic          r_prebuf, n_prebuf;
    logic          r_out_valid;

    // Item in flight
    logic [1:0]                 r_action;
    logic signed [SCALED_W-1:0] r_scaled;
    pasf_pkg::t_out_item        r_out_item, n_out_item;

    logic                       w_accept;
    logic                       w_commit;
    logic                       w_ram_we;
    logic [SW-1:0]              w_rdata;
    logic signed [7:0]          w_cent;
    logic signed [4:0]          w_gain;
    logic signed [12:0]         w_prod;
    logic signed [12:0]         w_shift;
    logic signed [SCALED_W-1:0] w_scaled;
    logic signed [18:0]         w_conv;
    logic [XW-1:0]              w_cnt_x;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign w_cnt_x     = XW'(r_fill_count);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume       <= pasf_pkg::RST_VOLUME;
            r_sound_enable <= pasf_pkg::RST_SOUND_ENABLE;
            r_start_level  <= pasf_pkg::RST_START_LEVEL;
            r_fill_limit   <= pasf_pkg::RST_FILL_LIMIT;
            r_resume_floor <= pasf_pkg::RST_RESUME_FLOOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pasf_pkg::CFG_VOLUME:       r_volume       <= i_cfg_data[2:0];
                pasf_pkg::CFG_SOUND_ENABLE: r_sound_enable <= i_cfg_data[0];
                pasf_pkg::CFG_START_LEVEL:  r_start_level  <= i_cfg_data;
                pasf_pkg::CFG_FILL_LIMIT:   r_fill_limit   <= i_cfg_data;
                pasf_pkg::CFG_RESUME_FLOOR: r_resume_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // First stage of the sample conversion: center, gain, shift
    assign w_cent  = {~i_in_item.sample_byte[7], i_in_item.sample_byte[6:0]};
    assign w_gain  = {1'b0, {1'b0, r_volume} + 4'd1};
    assign w_prod  = w_cent * w_gain;
    assign w_shift = w_prod >>> 3;

    always_comb begin
        if (!r_sound_enable || r_volume == 3'd0) begin
            w_scaled = '0;
        end else if (r_volume == pasf_pkg::VOL_FULL) begin
            w_scaled = {{(SCALED_W - 8){w_cent[7]}}, w_cent};
        end else begin
            w_scaled = w_shift[SCALED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_in_item.action;
            r_scaled <= w_scaled;
        end
    end

    // Second stage: scale by 127 for the stored 16-bit sample
    assign w_conv = r_scaled * $signed(8'sd127);

    // Ring memory, read always at the read pointer
    pasf_ram #(
        .WIDTH(SW),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_wr_ptr),
        .i_wdata(w_conv[SW-1:0]),
        .i_raddr(r_rd_ptr),
        .o_rdata(w_rdata)
    );

    // Item execution: pointer, count and prebuffer update plus result
    always_comb begin
        logic go_on;
        go_on        = 1'b1;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_fill_count = r_fill_count;
        n_prebuf     = r_prebuf;
        w_ram_we     = 1'b0;
        n_out_item   = '0;
        case (r_action)
            pasf_pkg::ACT_PUSH: begin
                if (w_cnt_x < XW'(r_fill_limit) && w_cnt_x < XW'(RING_DEPTH)) begin
                    w_ram_we     = w_commit;
                    n_wr_ptr     = (r_wr_ptr == PW'(RING_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + PW'(1);
                    n_fill_count = r_fill_count + CW'(1);
                    n_out_item.accepted = 1'b1;
                end
            end
            pasf_pkg::ACT_PULL: begin
                if (r_fill_count == '0) begin
                    n_out_item.underrun = 1'b1;
                end else if (!r_prebuf) begin
                    n_out_item.stereo_word = {w_rdata, w_rdata};
                    n_rd_ptr     = (r_rd_ptr == PW'(RING_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + PW'(1);
                    n_fill_count = r_fill_count - CW'(1);
                end
            end
            pasf_pkg::ACT_FRAME: begin
                // Exit test first, then the resume floor test in the same item
                if (r_prebuf) begin
                    if (w_cnt_x >= XW'(r_start_level)) begin
                        n_prebuf = 1'b0;
                    end else begin
                        go_on = 1'b0;
                    end
                end
                if (go_on && w_cnt_x < XW'(r_resume_floor)) begin
                    n_prebuf = 1'b1;
                end
            end
            default: ;
        endcase
        n_out_item.playing    = !n_prebuf;
        n_out_item.fill_level = LW'(XW'(n_fill_count));
    end

    // Sequencer: accept, then execute once the output register is free
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fill_count <= '0;
            r_prebuf     <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_wr_ptr     <= n_wr_ptr;
                r_rd_ptr     <= n_rd_ptr;
                r_fill_count <= n_fill_count;
                r_prebuf     <= n_prebuf;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    `ASSERT_CLK(a_count_in_range, w_cnt_x <= XW'(RING_DEPTH),
        "fill count exceeds ring depth")
    `ASSERT_NEXT(a_accept_to_exec, w_accept, r_state == S_EXEC && !o_in_ready,
        "accepted item did not enter execution")
    `ASSERT_NEXT(a_count_stable, !w_commit, $stable(r_fill_count),
        "fill count moved without an item commit")
    `ASSERT_CLK(a_result_flags, !(o_out_valid && o_out_item.accepted && o_out_item.underrun),
        "result flags both accepted and underrun")

endmodule
